FILE: rtl/hts_pkg.sv
package hts_pkg;

	// Result status codes.
	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MATCH   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	// Request command codes.
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Fixed field widths of the stream payload.
	localparam int unsigned HASH_W  = 64;
	localparam int unsigned TAG_W   = 32;
	localparam int unsigned DIST_W  = 7;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned NBYTES  = HASH_W / 8;

	typedef logic [NBYTES-1:0][3:0] byte_counts_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;   // capture the accepted request
		logic add;    // perform the append and load its status result
		logic issue;  // read the store entry at the scan address
		logic fin;    // load the closing result of a search
	} hts_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic adv;          // result register can take a new result
		logic store_empty;  // no entries stored
		logic addr_last;    // scan address is the last stored entry
		logic pipe_empty;   // no entry in flight in the compare pipeline
	} hts_sts_t;

	function automatic logic [3:0] popcnt8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

	function automatic logic [DIST_W-1:0] sum_counts(input byte_counts_t c);
		logic [DIST_W-1:0] s;
		s = '0;
		for (int i = 0; i < NBYTES; i++) begin
			s = s + DIST_W'(c[i]);
		end
		return s;
	endfunction

endpackage

FILE: rtl/hamming_threshold_hash_search_unit.sv
// Hamming threshold hash search unit. The block keeps a store of up to DEPTH
// perceptual hashes, each with a tag that identifies its source file. An add
// request (tuser 0) appends the hash and tag and returns one status result
// carrying the position written, or a full status when the store is full. A
// search request (tuser 1) compares the query hash against every stored entry
// in the order the entries were added, taking the Hamming distance as the
// popcount of the XOR. Every entry at or below max_distance produces one match
// result, and tlast marks the final one; a search that finds nothing returns a
// single no-match result. Only one request is in work at a time. An add is
// captured, then performed in the add state, which loads its status into the
// result register. A search reads the stored entries from the store memory one
// per cycle, while the result register can take a new result, through a
// three-stage read, popcount and compare pipeline. Back-pressure on the result
// stream stalls the scan without loss.
// The entry count clears at reset; the store memories need no clearing pass.
module hamming_threshold_hash_search_unit
	import hts_pkg::*;
#(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned HASH_BITS = 64,
	parameter int unsigned TAG_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] query_hash, [95:64] entry_tag, [102:96] max_distance, [103] zero
	input  logic [103:0] s_tdata,
	// [0] command
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [6:0] distance, [70:7] match_hash, [102:71] match_tag,
	// [108:103] match_index, [111:109] zero
	output logic [111:0] m_tdata,
	// [1:0] status
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	hts_cmd_t cmd;
	hts_sts_t sts;

	logic [DIST_W-1:0]  res_distance;
	logic [HASH_W-1:0]  res_hash;
	logic [TAG_W-1:0]   res_tag;
	logic [INDEX_W-1:0] res_index;

	// The controller sequences each request; the datapath holds the store,
	// the compare pipeline, the held match and the result register.
	hts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_command (s_tuser),
		.req_ready   (s_tready),
		.sts         (sts),
		.cmd         (cmd)
	);

	hts_dp #(
		.DEPTH     (DEPTH),
		.HASH_BITS (HASH_BITS),
		.TAG_BITS  (TAG_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_hash     (s_tdata[63:0]),
		.req_tag      (s_tdata[95:64]),
		.req_limit    (s_tdata[102:96]),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_status   (m_tuser),
		.res_distance (res_distance),
		.res_hash     (res_hash),
		.res_tag      (res_tag),
		.res_index    (res_index),
		.res_last     (m_tlast)
	);

	assign m_tdata = {3'b000, res_index, res_tag, res_hash, res_distance};

	// When a request is taken, no entry of an earlier search may be in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> sts.pipe_empty)
		else $error("compare pipeline busy while idle");

	// A request occupies the block: the next cycle never takes another one.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	// Status, full and no-match results always close their request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_STORED || m_tuser == ST_FULL ||
		m_tuser == ST_NOMATCH) |-> m_tlast)
		else $error("single result without last flag");

	// A match result never reports a distance above the full hash width.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_MATCH |-> res_distance <= 7'd64)
		else $error("match distance out of range");

endmodule

FILE: rtl/hts_ctrl.sv
module hts_ctrl
	import hts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_command,
	output logic     req_ready,
	input  hts_sts_t sts,
	output hts_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADD   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_command == CMD_ADD) ? S_ADD : S_SCAN;
				end
			end
			S_ADD: begin
				if (sts.adv) begin
					cmd.add = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.store_empty) begin
					state_d = S_DRAIN;
				end else if (sts.adv) begin
					cmd.issue = 1'b1;
					if (sts.addr_last) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.adv) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/hts_dp.sv
module hts_dp
	import hts_pkg::*;
#(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned HASH_BITS = 64,
	parameter int unsigned TAG_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hts_cmd_t           cmd,
	output hts_sts_t           sts,
	input  logic [HASH_W-1:0]  req_hash,
	input  logic [TAG_W-1:0]   req_tag,
	input  logic [DIST_W-1:0]  req_limit,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         res_status,
	output logic [DIST_W-1:0]  res_distance,
	output logic [HASH_W-1:0]  res_hash,
	output logic [TAG_W-1:0]   res_tag,
	output logic [INDEX_W-1:0] res_index,
	output logic               res_last
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [HASH_BITS-1:0] hash_mem [DEPTH];
	logic [TAG_BITS-1:0]  tag_mem  [DEPTH];

	logic [HASH_BITS-1:0] query_q;
	logic [TAG_BITS-1:0]  tag_in_q;
	logic [DIST_W-1:0]    limit_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        addr_q;

	logic                 v_s1;
	logic [HASH_BITS-1:0] hash_s1;
	logic [TAG_BITS-1:0]  tag_s1;
	logic [AW-1:0]        idx_s1;

	logic                 v_s2;
	logic [HASH_BITS-1:0] hash_s2;
	logic [TAG_BITS-1:0]  tag_s2;
	logic [AW-1:0]        idx_s2;
	byte_counts_t         bc_s2;

	logic                 pend_v_q;
	logic [HASH_BITS-1:0] pend_hash_q;
	logic [TAG_BITS-1:0]  pend_tag_q;
	logic [AW-1:0]        pend_idx_q;
	logic [DIST_W-1:0]    pend_dist_q;

	logic                 out_v_q;
	logic [1:0]           out_status_q;
	logic [DIST_W-1:0]    out_dist_q;
	logic [HASH_W-1:0]    out_hash_q;
	logic [TAG_W-1:0]     out_tag_q;
	logic [INDEX_W-1:0]   out_idx_q;
	logic                 out_last_q;

	logic                 adv;
	logic                 full;
	logic [HASH_W-1:0]    diff;
	logic [DIST_W-1:0]    dist_s2;
	logic                 match_s2;
	logic                 emit;
	logic [AW+INDEX_W-1:0] pend_idx_ext;
	logic [CW+INDEX_W-1:0] count_ext;

	assign adv      = !out_v_q || res_ready;
	assign full     = (count_q == CW'(DEPTH));
	assign diff     = HASH_W'(query_q ^ hash_s1);
	assign dist_s2  = sum_counts(bc_s2);
	assign match_s2 = v_s2 && (dist_s2 <= limit_q);
	assign emit     = (cmd.add && adv) || (cmd.fin && adv) || (match_s2 && pend_v_q && adv);

	// Positions are reported modulo the width of the index field.
	assign pend_idx_ext = {{INDEX_W{1'b0}}, pend_idx_q};
	assign count_ext    = {{INDEX_W{1'b0}}, count_q};

	assign sts.adv         = adv;
	assign sts.store_empty = (count_q == '0);
	assign sts.addr_last   = (CW'(addr_q) == count_q - CW'(1));
	assign sts.pipe_empty  = !v_s1 && !v_s2;

	// Storage and pipeline payload: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			query_q  <= HASH_BITS'(req_hash);
			tag_in_q <= TAG_BITS'(req_tag);
			limit_q  <= req_limit;
		end
		if (cmd.add && adv && !full) begin
			hash_mem[count_q[AW-1:0]] <= query_q;
			tag_mem[count_q[AW-1:0]]  <= tag_in_q;
		end
		if (adv) begin
			if (cmd.issue) begin
				hash_s1 <= hash_mem[addr_q];
				tag_s1  <= tag_mem[addr_q];
				idx_s1  <= addr_q;
			end
			hash_s2 <= hash_s1;
			tag_s2  <= tag_s1;
			idx_s2  <= idx_s1;
			for (int b = 0; b < NBYTES; b++) begin
				bc_s2[b] <= popcnt8(diff[8*b +: 8]);
			end
			if (match_s2) begin
				pend_hash_q <= hash_s2;
				pend_tag_q  <= tag_s2;
				pend_idx_q  <= idx_s2;
				pend_dist_q <= dist_s2;
			end
		end
		if (emit) begin
			if (cmd.add) begin
				out_status_q <= full ? ST_FULL : ST_STORED;
				out_dist_q   <= '0;
				out_hash_q   <= '0;
				out_tag_q    <= '0;
				out_idx_q    <= full ? '0 : count_ext[INDEX_W-1:0];
				out_last_q   <= 1'b1;
			end else if (cmd.fin && !pend_v_q) begin
				out_status_q <= ST_NOMATCH;
				out_dist_q   <= '0;
				out_hash_q   <= '0;
				out_tag_q    <= '0;
				out_idx_q    <= '0;
				out_last_q   <= 1'b1;
			end else begin
				// A held match goes out: it is the final one only at the close.
				out_status_q <= ST_MATCH;
				out_dist_q   <= pend_dist_q;
				out_hash_q   <= HASH_W'(pend_hash_q);
				out_tag_q    <= TAG_W'(pend_tag_q);
				out_idx_q    <= pend_idx_ext[INDEX_W-1:0];
				out_last_q   <= cmd.fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			addr_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q   <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.add && adv && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (adv) begin
				out_v_q <= emit;
				v_s1    <= cmd.issue;
				v_s2    <= v_s1;
				if (cmd.issue) begin
					addr_q <= addr_q + AW'(1);
				end
				if (match_s2) begin
					pend_v_q <= 1'b1;
				end
				if (cmd.fin) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	assign res_valid    = out_v_q;
	assign res_status   = out_status_q;
	assign res_distance = out_dist_q;
	assign res_hash     = out_hash_q;
	assign res_tag      = out_tag_q;
	assign res_index    = out_idx_q;
	assign res_last     = out_last_q;

endmodule
